// File: design/xcfd_pkg.sv
// ----------------------------------------------------------------------------
// xcfd_pkg
// Shared types and constants for the xor checked frame deframer.
// ----------------------------------------------------------------------------
package xcfd_pkg;

	// start of frame marker, also the checksum seed
	localparam logic [7:0] SOF_BYTE = 8'hFE;

	// reset value of the maximum payload length register
	localparam logic [15:0] MAX_LEN_RESET = 16'd128;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_GOOD    = 2'd1;
	localparam logic [1:0] KIND_BAD     = 2'd2;
	localparam logic [1:0] KIND_REJECT  = 2'd3;

	// receive phases
	typedef enum logic [2:0] {
		PH_WAIT = 3'd0,
		PH_FHI  = 3'd1,
		PH_FLO  = 3'd2,
		PH_LHI  = 3'd3,
		PH_LLO  = 3'd4,
		PH_DATA = 3'd5,
		PH_CSUM = 3'd6
	} phase_t;

	// one result from the parser to the output register
	typedef struct packed {
		logic        valid;
		logic [1:0]  kind;
		logic [15:0] func_code;
		logic [15:0] frame_len;
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
	} result_t;

endpackage

// File: design/xcfd_parser.sv
// ----------------------------------------------------------------------------
// xcfd_parser
// Frame state machine: header capture, payload indexing, xor checksum.
// ----------------------------------------------------------------------------
module xcfd_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	input  logic [7:0]           rx_byte,
	input  logic [15:0]          max_len,
	output xcfd_pkg::result_t    result
);

	xcfd_pkg::phase_t phase_q, phase_d;
	logic [15:0] func_q, func_d;
	logic [15:0] len_q, len_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  xor_q, xor_d;
	logic [15:0] count_inc;

	assign count_inc = count_q + 16'd1;

	// state registers, advanced once per accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= xcfd_pkg::PH_WAIT;
			func_q  <= '0;
			len_q   <= '0;
			count_q <= '0;
			xor_q   <= xcfd_pkg::SOF_BYTE;
		end else if (byte_valid) begin
			phase_q <= phase_d;
			func_q  <= func_d;
			len_q   <= len_d;
			count_q <= count_d;
			xor_q   <= xor_d;
		end
	end

	// next state and result
	always_comb begin
		phase_d = phase_q;
		func_d  = func_q;
		len_d   = len_q;
		count_d = count_q;
		xor_d   = xor_q;
		result  = '0;
		unique case (phase_q)
			xcfd_pkg::PH_WAIT: begin
				func_d  = '0;
				len_d   = '0;
				count_d = '0;
				xor_d   = xcfd_pkg::SOF_BYTE;
				if (rx_byte == xcfd_pkg::SOF_BYTE) begin
					phase_d = xcfd_pkg::PH_FHI;
				end
			end
			xcfd_pkg::PH_FHI: begin
				func_d  = {rx_byte, 8'h00};
				xor_d   = xor_q ^ rx_byte;
				phase_d = xcfd_pkg::PH_FLO;
			end
			xcfd_pkg::PH_FLO: begin
				func_d  = {func_q[15:8], func_q[7:0] | rx_byte};
				xor_d   = xor_q ^ rx_byte;
				phase_d = xcfd_pkg::PH_LHI;
			end
			xcfd_pkg::PH_LHI: begin
				len_d   = {rx_byte, 8'h00};
				xor_d   = xor_q ^ rx_byte;
				phase_d = xcfd_pkg::PH_LLO;
			end
			xcfd_pkg::PH_LLO: begin
				len_d = {len_q[15:8], len_q[7:0] | rx_byte};
				xor_d = xor_q ^ rx_byte;
				if (len_d > max_len) begin
					// declared length too long, report and drop the frame
					result.valid     = 1'b1;
					result.kind      = xcfd_pkg::KIND_REJECT;
					result.func_code = func_q;
					result.frame_len = len_d;
					phase_d          = xcfd_pkg::PH_WAIT;
				end else if (len_d == 16'd0) begin
					phase_d = xcfd_pkg::PH_CSUM;
				end else begin
					phase_d = xcfd_pkg::PH_DATA;
				end
			end
			xcfd_pkg::PH_DATA: begin
				result.valid      = 1'b1;
				result.kind       = xcfd_pkg::KIND_PAYLOAD;
				result.func_code  = func_q;
				result.frame_len  = len_q;
				result.data_byte  = rx_byte;
				result.byte_index = count_q;
				xor_d             = xor_q ^ rx_byte;
				count_d           = count_inc;
				if (count_inc == len_q) begin
					phase_d = xcfd_pkg::PH_CSUM;
				end
			end
			xcfd_pkg::PH_CSUM: begin
				result.valid     = 1'b1;
				result.kind      = (xor_q == rx_byte) ? xcfd_pkg::KIND_GOOD
				                                      : xcfd_pkg::KIND_BAD;
				result.func_code = func_q;
				result.frame_len = len_q;
				phase_d          = xcfd_pkg::PH_WAIT;
			end
			default: begin
				// unused phase code, drop the byte
				phase_d = xcfd_pkg::PH_WAIT;
			end
		endcase
		if (!byte_valid) begin
			result.valid = 1'b0;
		end
	end

endmodule

// File: design/xor_checked_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// xor_checked_frame_deframer_core
// Byte stream deframer for start-byte / length framed packets with xor check.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle on the slave stream and parses frames of
// the form 0xFE, function code (2 bytes, msb first), payload length (2 bytes,
// msb first), payload, xor checksum. Each payload byte leaves on the master
// stream with its index; the checksum byte yields a good or bad verdict, and
// a length above cfg_data's register value yields a reject. The frame state
// machine updates as each byte is taken and the result goes into a single
// output register, so a new byte is taken every cycle while that register
// is empty or being drained. The maximum length register resets to 128 and
// should be written only while no frame is in flight.
module xor_checked_frame_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	// input byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [15:0] func_code, [31:16] frame_len,
	                               // [39:32] data_byte, [55:40] byte_index
	output logic [1:0]  m_tuser,   // [1:0] kind
	// maximum payload length register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic [15:0]       max_len_q;
	logic              accept;
	xcfd_pkg::result_t result;
	xcfd_pkg::result_t out_q;
	logic              out_valid_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= xcfd_pkg::MAX_LEN_RESET;
		end else if (cfg_valid) begin
			max_len_q <= cfg_data;
		end
	end

	xcfd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (accept),
		.rx_byte    (s_tdata),
		.max_len    (max_len_q),
		.result     (result)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (result.valid) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {out_q.byte_index, out_q.data_byte, out_q.frame_len, out_q.func_code};

endmodule
